@@ hdl/ceq_pkg.sv @@
// ----------------------------------------------------------------------------
// ceq_pkg
// Types and constants shared by the coalescing event queue.
// ----------------------------------------------------------------------------
package ceq_pkg;

    localparam int DEFAULT_CAPACITY = 16;

    localparam int KIND_W    = 4;
    localparam int PAYLOAD_W = 64;
    localparam int SEQ_W     = 32;
    localparam int STATUS_W  = 3;

    localparam logic [KIND_W-1:0] KIND_LAST_COALESCIBLE = 4'd3;
    localparam logic [KIND_W-1:0] KIND_DESTROYED        = 4'd4;

    localparam logic OP_ENQUEUE = 1'b0;
    localparam logic OP_DEQUEUE = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_QUEUED    = 3'd0,
        ST_COALESCED = 3'd1,
        ST_DROPPED   = 3'd2,
        ST_DEQUEUED  = 3'd3,
        ST_EMPTY     = 3'd4
    } status_t;

    typedef struct packed {
        logic [KIND_W-1:0]    kind;
        logic [PAYLOAD_W-1:0] payload;
        logic [SEQ_W-1:0]     seq;
    } entry_t;

    function automatic logic is_coalescible(input logic [KIND_W-1:0] kind);
        return kind <= KIND_LAST_COALESCIBLE;
    endfunction

endpackage

@@ hdl/ceq_store.sv @@
// ----------------------------------------------------------------------------
// ceq_store
// Event storage: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module ceq_store
    import ceq_pkg::*;
#(
    parameter int CAPACITY = DEFAULT_CAPACITY,
    parameter int PTR_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
)
(
    input  logic             clk,
    input  logic             wr_en,
    input  logic [PTR_W-1:0] wr_addr,
    input  entry_t           wr_data,
    input  logic             rd_en,
    input  logic [PTR_W-1:0] rd_addr,
    output entry_t           rd_data
);

    entry_t mem [CAPACITY];
    entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ hdl/coalescing_event_queue_unit.sv @@
// ----------------------------------------------------------------------------
// coalescing_event_queue_unit
// Bounded event ring with tail coalescing and displacement when full.
// ----------------------------------------------------------------------------
// Steps: a dequeue reads the oldest entry and then returns it; an enqueue scans the
//   coalescible tail from the newest entry back, then, if full, searches for a victim
//   and, if one is found, shifts later entries down over it and appends; one read port.
// Throughput: one beat at a time; busy high until done, low for suppressed/empty beats.
// The receiver cannot stall: done pulses for one cycle with the result.
// Reset: empty ring, counters zero, suppress clear; storage is not cleared.
module coalescing_event_queue_unit
    import ceq_pkg::*;
#(
    parameter int CAPACITY = DEFAULT_CAPACITY,
    parameter int CNT_W    = $clog2(CAPACITY + 1),
    parameter int PTR_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic                 cfg_write,
    input  logic                 cfg_data,
    input  logic                 operation,
    input  logic [KIND_W-1:0]    event_kind,
    input  logic [PAYLOAD_W-1:0] event_payload,
    output logic                 done,
    output logic [STATUS_W-1:0]  status,
    output logic [KIND_W-1:0]    out_kind,
    output logic [PAYLOAD_W-1:0] out_payload,
    output logic [SEQ_W-1:0]     out_sequence,
    output logic [SEQ_W-1:0]     dropped_total,
    output logic [CNT_W-1:0]     fill_level
);

    typedef enum logic [8:0] {
        S_IDLE     = 9'b000000001,
        S_SCAN_RD  = 9'b000000010,
        S_SCAN_CHK = 9'b000000100,
        S_FULL_CHK = 9'b000001000,
        S_FIND_RD  = 9'b000010000,
        S_FIND_CHK = 9'b000100000,
        S_SHIFT_RD = 9'b001000000,
        S_SHIFT_WR = 9'b010000000,
        S_APPEND   = 9'b100000000
    } state_t;

    localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);
    localparam logic [CNT_W-1:0] ONE_C = CNT_W'(1);

    state_t               state_reg, state_next;
    logic [PTR_W-1:0]     head_reg, head_next;
    logic [CNT_W-1:0]     held_reg, held_next;
    logic [SEQ_W-1:0]     seq_reg, seq_next;
    logic [SEQ_W-1:0]     drop_reg, drop_next;
    logic                 suppress_reg;
    logic [CNT_W-1:0]     idx_reg, idx_next;
    logic [KIND_W-1:0]    kind_reg, kind_next;
    logic [PAYLOAD_W-1:0] payload_reg, payload_next;
    logic                 deq_wait_reg, deq_wait_next;

    logic                 done_reg, done_next;
    status_t              status_reg, status_next;
    entry_t               out_reg, out_next;

    logic                 rd_en, wr_en;
    logic [CNT_W-1:0]     rd_logical, wr_logical;
    entry_t               wr_data, rd_data;

    function automatic logic [PTR_W-1:0] slot_of(input logic [PTR_W-1:0] head,
                                                 input logic [CNT_W-1:0] logical);
        logic [CNT_W:0] sum;
        sum = (CNT_W+1)'(head) + (CNT_W+1)'(logical);
        if (sum >= (CNT_W+1)'(CAPACITY))
        begin
            sum = sum - (CNT_W+1)'(CAPACITY);
        end
        return sum[PTR_W-1:0];
    endfunction

    ceq_store #(
        .CAPACITY (CAPACITY),
        .PTR_W    (PTR_W)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (slot_of(head_reg, wr_logical)),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (slot_of(head_reg, rd_logical)),
        .rd_data (rd_data)
    );

    always_comb
    begin
        state_next    = state_reg;
        head_next     = head_reg;
        held_next     = held_reg;
        seq_next      = seq_reg;
        drop_next     = drop_reg;
        idx_next      = idx_reg;
        kind_next     = kind_reg;
        payload_next  = payload_reg;
        deq_wait_next = 1'b0;
        done_next     = 1'b0;
        status_next   = status_reg;
        out_next      = out_reg;
        rd_en         = 1'b0;
        wr_en         = 1'b0;
        rd_logical    = idx_reg;
        wr_logical    = idx_reg;
        wr_data       = '{kind: kind_reg, payload: payload_reg, seq: seq_reg};

        unique case (state_reg)
            S_IDLE:
            begin
                if (deq_wait_reg)
                begin
                    done_next   = 1'b1;
                    status_next = ST_DEQUEUED;
                    out_next    = rd_data;
                    head_next   = (head_reg == PTR_W'(CAPACITY - 1)) ? '0 : head_reg + 1'b1;
                    held_next   = held_reg - ONE_C;
                end
                else if (start)
                begin
                    kind_next    = event_kind;
                    payload_next = event_payload;
                    out_next     = '0;
                    if (operation == OP_DEQUEUE)
                    begin
                        if (held_reg == '0)
                        begin
                            done_next   = 1'b1;
                            status_next = ST_EMPTY;
                        end
                        else
                        begin
                            rd_en         = 1'b1;
                            rd_logical    = '0;
                            deq_wait_next = 1'b1;
                        end
                    end
                    else if (suppress_reg)
                    begin
                        done_next   = 1'b1;
                        status_next = ST_COALESCED;
                    end
                    else if (is_coalescible(event_kind) && held_reg != '0)
                    begin
                        idx_next   = held_reg - ONE_C;
                        state_next = S_SCAN_RD;
                    end
                    else
                    begin
                        state_next = S_FULL_CHK;
                    end
                end
            end
            S_SCAN_RD:
            begin
                rd_en      = 1'b1;
                state_next = S_SCAN_CHK;
            end
            S_SCAN_CHK:
            begin
                priority if (!is_coalescible(rd_data.kind))
                begin
                    state_next = S_FULL_CHK;
                end
                else if (rd_data.kind == kind_reg)
                begin
                    wr_en       = 1'b1;
                    wr_data     = '{kind: kind_reg, payload: payload_reg, seq: rd_data.seq};
                    done_next   = 1'b1;
                    status_next = ST_COALESCED;
                    state_next  = S_IDLE;
                end
                else if (idx_reg == '0)
                begin
                    state_next = S_FULL_CHK;
                end
                else
                begin
                    idx_next   = idx_reg - ONE_C;
                    state_next = S_SCAN_RD;
                end
            end
            S_FULL_CHK:
            begin
                idx_next   = '0;
                state_next = (held_reg >= CAP_C) ? S_FIND_RD : S_APPEND;
            end
            S_FIND_RD:
            begin
                rd_en      = 1'b1;
                state_next = S_FIND_CHK;
            end
            S_FIND_CHK:
            begin
                priority if (is_coalescible(rd_data.kind))
                begin
                    state_next = S_SHIFT_RD;
                end
                else if (idx_reg + ONE_C < held_reg)
                begin
                    idx_next   = idx_reg + ONE_C;
                    state_next = S_FIND_RD;
                end
                else if (kind_reg == KIND_DESTROYED)
                begin
                    idx_next   = '0;
                    state_next = S_SHIFT_RD;
                end
                else
                begin
                    drop_next   = drop_reg + 1'b1;
                    done_next   = 1'b1;
                    status_next = ST_DROPPED;
                    state_next  = S_IDLE;
                end
            end
            S_SHIFT_RD:
            begin
                if (idx_reg + ONE_C < held_reg)
                begin
                    rd_en      = 1'b1;
                    rd_logical = idx_reg + ONE_C;
                    state_next = S_SHIFT_WR;
                end
                else
                begin
                    held_next  = held_reg - ONE_C;
                    drop_next  = drop_reg + 1'b1;
                    state_next = S_APPEND;
                end
            end
            S_SHIFT_WR:
            begin
                wr_en      = 1'b1;
                wr_data    = rd_data;
                idx_next   = idx_reg + ONE_C;
                state_next = S_SHIFT_RD;
            end
            S_APPEND:
            begin
                wr_en       = 1'b1;
                wr_logical  = held_reg;
                seq_next    = seq_reg + 1'b1;
                held_next   = held_reg + ONE_C;
                done_next   = 1'b1;
                status_next = ST_QUEUED;
                state_next  = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            head_reg     <= '0;
            held_reg     <= '0;
            seq_reg      <= '0;
            drop_reg     <= '0;
            suppress_reg <= 1'b0;
            deq_wait_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            head_reg     <= head_next;
            held_reg     <= held_next;
            seq_reg      <= seq_next;
            drop_reg     <= drop_next;
            deq_wait_reg <= deq_wait_next;
            done_reg     <= done_next;
            if (cfg_write)
            begin
                suppress_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg     <= idx_next;
        kind_reg    <= kind_next;
        payload_reg <= payload_next;
        status_reg  <= status_next;
        out_reg     <= out_next;
    end

    assign busy          = (state_reg != S_IDLE) || deq_wait_reg;
    assign done          = done_reg;
    assign status        = status_reg;
    assign out_kind      = out_reg.kind;
    assign out_payload   = out_reg.payload;
    assign out_sequence  = out_reg.seq;
    assign dropped_total = drop_reg;
    assign fill_level    = held_reg;

endmodule

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the coalescing event queue: a behavioral queue
// model predicts status, dequeued event, drop count and fill for each beat;
// directed and random phases run with and without sender gaps and with
// suppression toggled between phases.
// ----------------------------------------------------------------------------
module testbench;
    import ceq_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAP = DEFAULT_CAPACITY;

    typedef struct {
        logic [STATUS_W-1:0]  st;
        logic [KIND_W-1:0]    kind;
        logic [PAYLOAD_W-1:0] payload;
        logic [SEQ_W-1:0]     seq;
        logic [SEQ_W-1:0]     drops;
        logic [4:0]           fill;
    } outcome_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic                 cfg_write = 1'b0;
    logic                 cfg_data = 1'b0;
    logic                 operation = OP_ENQUEUE;
    logic [KIND_W-1:0]    event_kind = '0;
    logic [PAYLOAD_W-1:0] event_payload = '0;
    logic                 done;
    logic [STATUS_W-1:0]  status;
    logic [KIND_W-1:0]    out_kind;
    logic [PAYLOAD_W-1:0] out_payload;
    logic [SEQ_W-1:0]     out_sequence;
    logic [SEQ_W-1:0]     dropped_total;
    logic [4:0]           fill_level;

    coalescing_event_queue_unit dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .cfg_write(cfg_write), .cfg_data(cfg_data),
        .operation(operation), .event_kind(event_kind),
        .event_payload(event_payload), .done(done), .status(status),
        .out_kind(out_kind), .out_payload(out_payload),
        .out_sequence(out_sequence), .dropped_total(dropped_total),
        .fill_level(fill_level)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #40ms;
        $display("Timeout");
        $display("Mismatches found");
        $finish;
    end

    // queue model, logical order (index 0 = oldest)
    logic [KIND_W-1:0]    q_kind[$];
    logic [PAYLOAD_W-1:0] q_payload[$];
    logic [SEQ_W-1:0]     q_seq[$];
    logic [SEQ_W-1:0]     seq_next = '0;
    logic [SEQ_W-1:0]     drop_cnt = '0;
    logic                 suppress_on = 1'b0;
    outcome_t             pending[$];
    int                   errors = 0;
    int                   beats = 0;
    int                   gap_pct = 0;
    int                   n_deq = 0, n_coal = 0, n_drop = 0, n_disp = 0;

    function automatic outcome_t predict_queue(logic op, logic [KIND_W-1:0] k,
                                               logic [PAYLOAD_W-1:0] p);
        outcome_t r;
        int victim;
        r = '{ST_QUEUED, '0, '0, '0, '0, '0};
        if (op == OP_DEQUEUE) begin
            if (q_kind.size() == 0)
                r.st = ST_EMPTY;
            else begin
                r.st = ST_DEQUEUED;
                r.kind = q_kind.pop_front();
                r.payload = q_payload.pop_front();
                r.seq = q_seq.pop_front();
                n_deq++;
            end
        end else if (suppress_on)
            r.st = ST_COALESCED;
        else begin
            if (k <= KIND_LAST_COALESCIBLE) begin
                for (int i = q_kind.size() - 1; i >= 0; i--) begin
                    if (q_kind[i] > KIND_LAST_COALESCIBLE)
                        break;
                    if (q_kind[i] == k) begin
                        q_payload[i] = p;
                        r.st = ST_COALESCED;
                        n_coal++;
                        break;
                    end
                end
            end
            if (r.st != ST_COALESCED && q_kind.size() >= CAP) begin
                victim = -1;
                foreach (q_kind[i])
                    if (victim < 0 && q_kind[i] <= KIND_LAST_COALESCIBLE)
                        victim = i;
                if (victim < 0 && k == KIND_DESTROYED)
                    victim = 0;
                drop_cnt++;
                if (victim < 0) begin
                    r.st = ST_DROPPED;
                    n_drop++;
                end else begin
                    q_kind.delete(victim);
                    q_payload.delete(victim);
                    q_seq.delete(victim);
                    n_disp++;
                end
            end
            if (r.st == ST_QUEUED) begin
                q_kind.push_back(k);
                q_payload.push_back(p);
                q_seq.push_back(seq_next);
                seq_next++;
            end
        end
        r.drops = drop_cnt;
        r.fill = 5'(q_kind.size());
        return r;
    endfunction

    always @(posedge clk)
    begin
        outcome_t e;
        if (done) begin
            if (pending.size() == 0) begin
                $display("%0t: result with none expected, status %0d", $time, status);
                errors++;
            end else begin
                e = pending.pop_front();
                if (status !== e.st || out_kind !== e.kind || out_payload !== e.payload
                    || out_sequence !== e.seq || dropped_total !== e.drops
                    || fill_level !== e.fill) begin
                    $display("%0t: expected st %0d k %0d p %h s %0d d %0d f %0d", $time,
                             e.st, e.kind, e.payload, e.seq, e.drops, e.fill);
                    $display("%0t: actual   st %0d k %0d p %h s %0d d %0d f %0d", $time,
                             status, out_kind, out_payload, out_sequence,
                             dropped_total, fill_level);
                    errors++;
                end
            end
        end
    end

    task automatic send_beat(logic op, logic [KIND_W-1:0] k, logic [PAYLOAD_W-1:0] p);
        while ($urandom_range(99) < gap_pct)
            @(posedge clk);
        start <= 1'b1;
        operation <= op;
        event_kind <= k;
        event_payload <= p;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending.push_back(predict_queue(op, k, p));
        beats++;
        start <= 1'b0;
        @(posedge clk);
    endtask

    task automatic wait_idle();
        while (pending.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_suppress(logic v);
        wait_idle();
        cfg_write <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_write <= 1'b0;
        suppress_on = v;
        @(posedge clk);
    endtask

    function automatic logic [PAYLOAD_W-1:0] rand_payload();
        return {$urandom(), $urandom()};
    endfunction

    task automatic test_directed();
        send_beat(OP_DEQUEUE, 4'd0, '0);
        send_beat(OP_ENQUEUE, 4'd0, '1);
        send_beat(OP_ENQUEUE, 4'd0, '0);
        send_beat(OP_ENQUEUE, 4'd15, 64'h8000_0000_0000_0001);
        send_beat(OP_ENQUEUE, 4'd0, 64'h1234);
        for (int i = 0; i < 14; i++)
            send_beat(OP_ENQUEUE, (i % 2) ? 4'd4 : 4'd9, rand_payload());
        send_beat(OP_ENQUEUE, 4'd7, '1);
        send_beat(OP_ENQUEUE, KIND_DESTROYED, '0);
        send_beat(OP_DEQUEUE, 4'd0, '0);
        send_beat(OP_DEQUEUE, 4'd0, '0);
        set_suppress(1'b1);
        send_beat(OP_ENQUEUE, 4'd2, '1);
        set_suppress(1'b0);
    endtask

    task automatic test_random(int count, int gap);
        logic [KIND_W-1:0] k;
        gap_pct = gap;
        for (int i = 0; i < count; i++) begin
            k = ($urandom_range(2) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(5));
            if ($urandom_range(99) < ((q_kind.size() > 12) ? 30 : 42))
                send_beat(OP_DEQUEUE, 4'($urandom_range(15)), rand_payload());
            else
                send_beat(OP_ENQUEUE, k, rand_payload());
        end
        gap_pct = 0;
    endtask

    task automatic test_drain();
        wait_idle();
        while (q_kind.size() != 0)
            send_beat(OP_DEQUEUE, '0, '0);
        send_beat(OP_DEQUEUE, '0, '0);
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(300, 0);
        set_suppress(1'b1);
        test_random(80, 45);
        set_suppress(1'b0);
        test_random(300, 45);
        test_drain();
        test_random(300, 37);
        test_random(150, 0);
        wait_idle();
        repeat (80) @(posedge clk);
        $display("Covered %0d beats: %0d dequeues, %0d coalesced, %0d displaced, %0d dropped",
                 beats, n_deq, n_coal, n_disp, n_drop);
        $display("Suppression toggled; sender gap phases 0, 37 and 45 percent");
        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule

@@ filelist.f @@
hdl/ceq_pkg.sv
hdl/ceq_store.sv
hdl/coalescing_event_queue_unit.sv
tb/testbench.sv
